@@ rtl/trpd_pkg.sv @@
package trpd_pkg;

  // raster and count geometry
  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 240;
  localparam int COUNT_BITS    = 14;
  localparam int PALETTE_SIZE  = 52;
  localparam int LETTERS       = 26;
  localparam int QUEUE_DEPTH   = 2;

  // widths fixed by the span fields
  localparam int COL_W = 9;
  localparam int ROW_W = 8;
  localparam int LEN_W = 9;
  localparam int CLR_W = 16;

  // run counter width, wide enough to compare against a row's room
  localparam int CMP_W  = (COUNT_BITS > LEN_W) ? COUNT_BITS : LEN_W;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [5:0]            PAL_NONE  = 6'(PALETTE_SIZE);

  // character codes
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_UP_A  = 8'h41;
  localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
  localparam logic [7:0] CHAR_LOW_A = 8'h61;
  localparam logic [7:0] CHAR_LOW_Z = 8'h7A;

  // run release command, front to back
  typedef struct packed {
    logic [CLR_W-1:0]      color;
    logic [COUNT_BITS-1:0] count;
    logic                  at_end;
    logic                  has_run;
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_e;

  function automatic logic [CLR_W-1:0] rgb565(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  function automatic logic [CLR_W-1:0] palette_color(logic [5:0] idx);
    logic [CLR_W-1:0] c;
    unique case (idx)
      6'd0:  c = rgb565(8'd63,  8'd67,  8'd40);
      6'd1:  c = rgb565(8'd95,  8'd113, 8'd50);
      6'd2:  c = rgb565(8'd148, 8'd173, 8'd57);
      6'd3:  c = rgb565(8'd194, 8'd214, 8'd79);
      6'd4:  c = rgb565(8'd239, 8'd243, 8'd124);
      6'd5:  c = rgb565(8'd227, 8'd230, 8'd172);
      6'd6:  c = rgb565(8'd165, 8'd198, 8'd124);
      6'd7:  c = rgb565(8'd115, 8'd154, 8'd112);
      6'd8:  c = rgb565(8'd77,  8'd102, 8'd89);
      6'd9:  c = rgb565(8'd52,  8'd63,  8'd65);
      6'd10: c = rgb565(8'd40,  8'd46,  8'd59);
      6'd11: c = rgb565(8'd26,  8'd31,  8'd46);
      6'd12: c = rgb565(8'd30,  8'd49,  8'd75);
      6'd13: c = rgb565(8'd47,  8'd76,  8'd108);
      6'd14: c = rgb565(8'd61,  8'd128, 8'd163);
      6'd15: c = rgb565(8'd99,  8'd196, 8'd204);
      6'd16: c = rgb565(8'd154, 8'd229, 8'd213);
      6'd17: c = rgb565(8'd229, 8'd239, 8'd239);
      6'd18: c = rgb565(8'd186, 8'd201, 8'd205);
      6'd19: c = rgb565(8'd141, 8'd153, 8'd164);
      6'd20: c = rgb565(8'd105, 8'd111, 8'd128);
      6'd21: c = rgb565(8'd65,  8'd68,  8'd83);
      6'd22: c = rgb565(8'd184, 8'd161, 8'd194);
      6'd23: c = rgb565(8'd126, 8'd101, 8'd155);
      6'd24: c = rgb565(8'd92,  8'd58,  8'd111);
      6'd25: c = rgb565(8'd57,  8'd39,  8'd94);
      6'd26: c = rgb565(8'd47,  8'd25,  8'd62);
      6'd27: c = rgb565(8'd78,  8'd26,  8'd73);
      6'd28: c = rgb565(8'd123, 8'd35,  8'd76);
      6'd29: c = rgb565(8'd178, 8'd54,  8'd87);
      6'd30: c = rgb565(8'd209, 8'd105, 8'd116);
      6'd31: c = rgb565(8'd237, 8'd170, 8'd163);
      6'd32: c = rgb565(8'd238, 8'd203, 8'd144);
      6'd33: c = rgb565(8'd225, 8'd168, 8'd69);
      6'd34: c = rgb565(8'd197, 8'd120, 8'd53);
      6'd35: c = rgb565(8'd141, 8'd72,  8'd48);
      6'd36: c = rgb565(8'd228, 8'd114, 8'd89);
      6'd37: c = rgb565(8'd195, 8'd60,  8'd64);
      6'd38: c = rgb565(8'd141, 8'd54,  8'd73);
      6'd39: c = rgb565(8'd92,  8'd43,  8'd52);
      6'd40: c = rgb565(8'd60,  8'd37,  8'd43);
      6'd41: c = rgb565(8'd104, 8'd64,  8'd57);
      6'd42: c = rgb565(8'd130, 8'd86,  8'd70);
      6'd43: c = rgb565(8'd183, 8'd120, 8'd98);
      6'd44: c = rgb565(8'd125, 8'd89,  8'd93);
      6'd45: c = rgb565(8'd83,  8'd59,  8'd65);
      6'd46: c = rgb565(8'd63,  8'd51,  8'd59);
      6'd47: c = rgb565(8'd43,  8'd34,  8'd42);
      6'd48: c = rgb565(8'd109, 8'd78,  8'd75);
      6'd49: c = rgb565(8'd134, 8'd112, 8'd102);
      6'd50: c = rgb565(8'd180, 8'd157, 8'd126);
      6'd51: c = rgb565(8'd196, 8'd198, 8'd184);
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/trpd_front.sv @@
module trpd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          code_byte_i,
  input  logic                full_i,
  output logic                push_o,
  output trpd_pkg::cmd_t      cmd_o
);

  logic                                 pending_q, pending_d;
  logic [trpd_pkg::CLR_W-1:0]           color_q, color_d;
  logic [trpd_pkg::COUNT_BITS-1:0]      count_q, count_d;
  logic                                 accept;
  logic                                 is_zero, is_digit;
  logic [5:0]                           pal_idx;
  logic [trpd_pkg::COUNT_BITS+3:0]      acc;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;

  assign is_zero  = (code_byte_i == trpd_pkg::CHAR_NUL);
  assign is_digit = (code_byte_i >= trpd_pkg::CHAR_ZERO) && (code_byte_i <= trpd_pkg::CHAR_NINE);

  // count * 10 + digit
  assign acc = {count_q, 3'b000} + {2'b00, count_q, 1'b0}
             + {(trpd_pkg::COUNT_BITS)'(0), code_byte_i[3:0]};

  always_comb begin
    if (code_byte_i >= trpd_pkg::CHAR_UP_A && code_byte_i <= trpd_pkg::CHAR_UP_Z) begin
      pal_idx = 6'(code_byte_i - trpd_pkg::CHAR_UP_A);
    end else if (code_byte_i >= trpd_pkg::CHAR_LOW_A && code_byte_i <= trpd_pkg::CHAR_LOW_Z) begin
      pal_idx = 6'(code_byte_i - trpd_pkg::CHAR_LOW_A) + 6'(trpd_pkg::LETTERS);
    end else begin
      pal_idx = trpd_pkg::PAL_NONE;
    end
  end

  always_comb begin
    pending_d     = pending_q;
    color_d       = color_q;
    count_d       = count_q;
    push_o        = 1'b0;
    cmd_o.color   = color_q;
    cmd_o.count   = count_q;
    cmd_o.at_end  = 1'b0;
    cmd_o.has_run = pending_q;
    if (accept) begin
      if (is_zero) begin
        // terminator: flush the run, and the position resets in the back end
        push_o       = 1'b1;
        cmd_o.at_end = 1'b1;
        pending_d    = 1'b0;
        count_d      = '0;
      end else if (pending_q && is_digit) begin
        if (acc > {4'b0000, trpd_pkg::COUNT_MAX}) begin
          count_d = trpd_pkg::COUNT_MAX;
        end else begin
          count_d = acc[trpd_pkg::COUNT_BITS-1:0];
        end
      end else begin
        push_o    = pending_q;
        pending_d = 1'b1;
        count_d   = '0;
        if (pal_idx < trpd_pkg::PAL_NONE) begin
          color_d = trpd_pkg::palette_color(pal_idx);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
      color_q   <= '0;
      count_q   <= '0;
    end else begin
      pending_q <= pending_d;
      color_q   <= color_d;
      count_q   <= count_d;
    end
  end

endmodule

@@ rtl/trpd_queue.sv @@
module trpd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  trpd_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output trpd_pkg::cmd_t cmd_o
);

  trpd_pkg::cmd_t                 mem_q [trpd_pkg::QUEUE_DEPTH];
  logic [trpd_pkg::QPTR_W-1:0]    wr_ptr_q, rd_ptr_q;
  logic [trpd_pkg::QCNT_W-1:0]    cnt_q;
  logic                           do_push, do_pop;

  assign full_o  = (cnt_q == trpd_pkg::QCNT_W'(trpd_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rd_ptr_q];

  function automatic logic [trpd_pkg::QPTR_W-1:0] ptr_inc(logic [trpd_pkg::QPTR_W-1:0] p);
    if (p == trpd_pkg::QPTR_W'(trpd_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

@@ rtl/trpd_back.sv @@
module trpd_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        empty_i,
  input  trpd_pkg::cmd_t              cmd_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [trpd_pkg::COL_W-1:0]  span_x_o,
  output logic [trpd_pkg::ROW_W-1:0]  span_y_o,
  output logic [trpd_pkg::LEN_W-1:0]  span_length_o,
  output logic [trpd_pkg::CLR_W-1:0]  pixel_color_o,
  output logic                        run_last_o,
  output logic                        image_end_o
);

  trpd_pkg::back_state_e             state_q, state_d;
  logic [trpd_pkg::COL_W-1:0]        col_q, col_d;
  logic [trpd_pkg::ROW_W-1:0]        row_q, row_d;
  logic [trpd_pkg::CMP_W-1:0]        left_q, left_d;
  logic [trpd_pkg::CLR_W-1:0]        color_q, color_d;
  logic                              at_end_q, at_end_d;

  logic                              ov_q, ov_d;
  logic                              load;
  logic [trpd_pkg::COL_W-1:0]        ox_q;
  logic [trpd_pkg::ROW_W-1:0]        oy_q;
  logic [trpd_pkg::LEN_W-1:0]        olen_q;
  logic [trpd_pkg::CLR_W-1:0]        ocolor_q;
  logic                              olast_q, oend_q;

  logic                              out_ready;
  logic                              below;
  logic [trpd_pkg::COL_W-1:0]        room;
  logic [trpd_pkg::LEN_W-1:0]        len;
  logic                              wraps, last;
  logic [trpd_pkg::CMP_W-1:0]        new_left;

  assign out_ready = !ov_q || !out_stall_i;
  assign below     = ({1'b0, row_q} >= (trpd_pkg::ROW_W+1)'(trpd_pkg::SCREEN_HEIGHT));
  assign room      = trpd_pkg::COL_W'(trpd_pkg::SCREEN_WIDTH) - col_q;

  always_comb begin
    if (left_q <= trpd_pkg::CMP_W'(room)) begin
      len = left_q[trpd_pkg::LEN_W-1:0];
    end else begin
      len = room;
    end
  end

  assign wraps    = (len == room);
  assign new_left = left_q - trpd_pkg::CMP_W'(len);
  assign last     = (new_left == '0) ||
                    (wraps && (({1'b0, row_q} + 1'b1) ==
                               (trpd_pkg::ROW_W+1)'(trpd_pkg::SCREEN_HEIGHT)));

  always_comb begin
    state_d  = state_q;
    col_d    = col_q;
    row_d    = row_q;
    left_d   = left_q;
    color_d  = color_q;
    at_end_d = at_end_q;
    pop_o    = 1'b0;
    load     = 1'b0;
    unique case (state_q)
      trpd_pkg::BK_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          if (cmd_i.has_run) begin
            color_d  = cmd_i.color;
            at_end_d = cmd_i.at_end;
            left_d   = (cmd_i.count == '0) ? trpd_pkg::CMP_W'(1)
                                           : trpd_pkg::CMP_W'(cmd_i.count);
            state_d  = trpd_pkg::BK_RUN;
          end else if (cmd_i.at_end) begin
            col_d = '0;
            row_d = '0;
          end
        end
      end
      trpd_pkg::BK_RUN: begin
        if (below) begin
          state_d = trpd_pkg::BK_IDLE;
          if (at_end_q) begin
            col_d = '0;
            row_d = '0;
          end
        end else if (out_ready) begin
          load   = 1'b1;
          left_d = new_left;
          if (wraps) begin
            col_d = '0;
            row_d = row_q + 1'b1;
          end else begin
            col_d = col_q + len;
          end
          if (last) begin
            state_d = trpd_pkg::BK_IDLE;
            if (at_end_q) begin
              col_d = '0;
              row_d = '0;
            end
          end
        end
      end
      default: state_d = trpd_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    ov_d = ov_q;
    if (load) begin
      ov_d = 1'b1;
    end else if (!out_stall_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= trpd_pkg::BK_IDLE;
      col_q    <= '0;
      row_q    <= '0;
      left_q   <= '0;
      color_q  <= '0;
      at_end_q <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      col_q    <= col_d;
      row_q    <= row_d;
      left_q   <= left_d;
      color_q  <= color_d;
      at_end_q <= at_end_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ox_q     <= col_q;
      oy_q     <= row_q;
      olen_q   <= len;
      ocolor_q <= color_q;
      olast_q  <= last;
      oend_q   <= at_end_q;
    end
  end

  assign out_valid_o   = ov_q;
  assign span_x_o      = ox_q;
  assign span_y_o      = oy_q;
  assign span_length_o = olen_q;
  assign pixel_color_o = ocolor_q;
  assign run_last_o    = olast_q;
  assign image_end_o   = oend_q;

endmodule

@@ rtl/text_rle_palette_decoder_unit.sv @@
// Palette run-length image decoder. Code bytes enter one beat per cycle on the
// input channel: a letter picks an RGB565 palette color (A-Z entries 0-25, a-z
// entries 26-51), any other symbol reuses the last color, and decimal digits
// after a symbol give its run count (none or zero means one pixel, saturating
// at 16383). A run is drawn when the next symbol or a zero byte arrives; it
// leaves as horizontal spans, one beat per span, cut at the row end and
// wrapping to the next row; spans below the last row are dropped. A zero byte
// flushes the pending run with image_end set and homes the position to the top
// left. Timing: the front end takes a byte every cycle while its two-entry
// command queue has room; the back end takes a run from the queue while idle
// and then emits its spans, one per cycle while the output is not stalled.
// The front end stalls only when the queue is full.
module text_rle_palette_decoder_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // code byte beats
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  code_byte_i,
  // span beats
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [trpd_pkg::COL_W-1:0]  span_x_o,
  output logic [trpd_pkg::ROW_W-1:0]  span_y_o,
  output logic [trpd_pkg::LEN_W-1:0]  span_length_o,
  output logic [trpd_pkg::CLR_W-1:0]  pixel_color_o,
  output logic                        run_last_o,
  output logic                        image_end_o
);

  // release commands between the classifier and the span generator
  trpd_pkg::cmd_t push_cmd, pop_cmd;
  logic           push, pop, q_full, q_empty;

  // front end: tracks the pending symbol, its color and its count
  trpd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .code_byte_i (code_byte_i),
    .full_i      (q_full),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  // short queue so long runs do not block byte intake at once
  trpd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .cmd_o   (pop_cmd)
  );

  // back end: owns the raster position and emits the spans
  trpd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (q_empty),
    .cmd_i         (pop_cmd),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .span_x_o      (span_x_o),
    .span_y_o      (span_y_o),
    .span_length_o (span_length_o),
    .pixel_color_o (pixel_color_o),
    .run_last_o    (run_last_o),
    .image_end_o   (image_end_o)
  );

endmodule

@@ rtl/trpd_checker.sv @@
module trpd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [trpd_pkg::COL_W-1:0]  span_x_o,
  input logic [trpd_pkg::ROW_W-1:0]  span_y_o,
  input logic [trpd_pkg::LEN_W-1:0]  span_length_o,
  input logic                        run_last_o,
  input logic                        image_end_o
);

  logic out_acc;
  logic home_q;

  assign out_acc = out_valid_o && !out_stall_i;

  // after the final span of an image the next span starts at the origin
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      home_q <= 1'b0;
    end else if (out_acc) begin
      home_q <= run_last_o && image_end_o;
    end
  end

  a_valid_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("span beat dropped while stalled");

  a_span_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (({1'b0, span_x_o} + {1'b0, span_length_o}) <=
                     (trpd_pkg::COL_W+1)'(trpd_pkg::SCREEN_WIDTH)))
    else $error("span runs past the row end");

  a_span_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (span_length_o != '0) &&
                    ({1'b0, span_y_o} < (trpd_pkg::ROW_W+1)'(trpd_pkg::SCREEN_HEIGHT)))
    else $error("empty span or span below the last row");

  a_home_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && home_q |-> (span_x_o == '0) && (span_y_o == '0))
    else $error("image did not restart at the origin");

endmodule

bind text_rle_palette_decoder_unit trpd_checker u_trpd_checker (.*);
